FILE: sv/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg
// Types, character codes and the character classifier shared by the
// bracket match checker.
// ----------------------------------------------------------------------------
package bmc_pkg;

  localparam logic [7:0]  CH_LPAREN = 8'h28;
  localparam logic [7:0]  CH_RPAREN = 8'h29;
  localparam logic [7:0]  CH_LBRACK = 8'h5B;
  localparam logic [7:0]  CH_RBRACK = 8'h5D;
  localparam logic [7:0]  CH_LBRACE = 8'h7B;
  localparam logic [7:0]  CH_RBRACE = 8'h7D;
  localparam logic [7:0]  CH_LANGLE = 8'h3C;
  localparam logic [7:0]  CH_RANGLE = 8'h3E;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_PAREN = 2'd0,
    KIND_BRACK = 2'd1,
    KIND_BRACE = 2'd2,
    KIND_ANGLE = 2'd3
  } kind_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } char_class_t;

  // shift control for the stack row
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

  typedef struct packed {
    logic [15:0] matched_pairs;
    logic        left_open;
    logic        mismatch_seen;
    logic        overflow_seen;
  } result_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.is_open  = 1'b0;
    r.is_close = 1'b0;
    r.kind     = KIND_PAREN;
    case (c)
      CH_LPAREN: begin r.is_open  = 1'b1; r.kind = KIND_PAREN; end
      CH_LBRACK: begin r.is_open  = 1'b1; r.kind = KIND_BRACK; end
      CH_LBRACE: begin r.is_open  = 1'b1; r.kind = KIND_BRACE; end
      CH_LANGLE: begin r.is_open  = 1'b1; r.kind = KIND_ANGLE; end
      CH_RPAREN: begin r.is_close = 1'b1; r.kind = KIND_PAREN; end
      CH_RBRACK: begin r.is_close = 1'b1; r.kind = KIND_BRACK; end
      CH_RBRACE: begin r.is_close = 1'b1; r.kind = KIND_BRACE; end
      CH_RANGLE: begin r.is_close = 1'b1; r.kind = KIND_ANGLE; end
      default: begin
        r.is_open  = 1'b0;
        r.is_close = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: sv/bmc_in_if.sv
// ----------------------------------------------------------------------------
// bmc_in_if
// Character request channel: valid/ready with one byte and an end marker.
// ----------------------------------------------------------------------------
interface bmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: sv/bmc_out_if.sv
// ----------------------------------------------------------------------------
// bmc_out_if
// Result request channel: valid/ready with pair count and status flags.
// ----------------------------------------------------------------------------
interface bmc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] matched_pairs;
  logic        left_open;
  logic        mismatch_seen;
  logic        overflow_seen;

  modport source (output valid, output matched_pairs, output left_open,
                  output mismatch_seen, output overflow_seen, input ready);
  modport sink   (input valid, input matched_pairs, input left_open,
                  input mismatch_seen, input overflow_seen, output ready);
endinterface

FILE: sv/bmc_stack_cell.sv
// ----------------------------------------------------------------------------
// bmc_stack_cell
// One entry of the shifting opener stack; takes the upper neighbor on a
// push and the lower neighbor on a pop.
// ----------------------------------------------------------------------------
module bmc_stack_cell
  import bmc_pkg::*;
(
  input  logic       clk,
  input  shift_ctl_t ctl,
  input  kind_t      from_above,
  input  kind_t      from_below,
  output kind_t      kind_q
);

  kind_t data_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data_r <= from_above;
    end else if (ctl.pop) begin
      data_r <= from_below;
    end
  end

  assign kind_q = data_r;

endmodule

FILE: sv/bmc_out_buf.sv
// ----------------------------------------------------------------------------
// bmc_out_buf
// Result register with one skid entry so the scan keeps running while a
// result waits on the output channel.
// ----------------------------------------------------------------------------
module bmc_out_buf
  import bmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  result_t   data,
  output logic      room,
  bmc_out_if.source out_ch
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    take;

  assign take = out_valid_r && out_ch.ready;
  assign room = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // no new request can arrive while the skid entry is full
      if (take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_data_nxt  = data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = data;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.matched_pairs = out_data_r.matched_pairs;
  assign out_ch.left_open     = out_data_r.left_open;
  assign out_ch.mismatch_seen = out_data_r.mismatch_seen;
  assign out_ch.overflow_seen = out_data_r.overflow_seen;

endmodule

FILE: sv/bracket_match_checker_top.sv
// The result is registered in the output buffer (output register, or skid
// entry while the output waits) when the request with last_char is accepted.
// One character per cycle while room is high; the stack row pushes or pops
// and the top cell is compared in the same cycle as the character arrives.
// Reset clears stack level, pair count, flags and the output buffer; the
// stack cells hold no reset and are only read below the current level.
// ----------------------------------------------------------------------------
// bracket_match_checker_top
// Balanced bracket checker built on a shifting row of stack cells, with the
// top of stack always in the first cell.
// ----------------------------------------------------------------------------
module bracket_match_checker_top
  import bmc_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bmc_in_if.sink    in_ch,
  bmc_out_if.source out_ch
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

  logic [LVL_W-1:0] level_r, level_nxt;
  logic [15:0]      count_r, count_nxt;
  logic             stopped_r, stopped_nxt;
  logic             mis_r, mis_nxt;
  logic             ovf_r, ovf_nxt;

  kind_t       slot_q [STACK_DEPTH];
  shift_ctl_t  ctl;
  char_class_t cls;
  logic        accept, act, room;
  logic        is_full, is_empty, do_push, do_pop, bad_close, push_full;
  result_t     res;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;
  assign cls         = classify(in_ch.char_code);
  assign act         = accept && !stopped_r;
  assign is_full     = (level_r == LVL_FULL);
  assign is_empty    = (level_r == '0);

  assign do_push   = act && cls.is_open && !is_full;
  assign push_full = act && cls.is_open && is_full;
  assign do_pop    = act && cls.is_close && !is_empty && (slot_q[0] == cls.kind);
  assign bad_close = act && cls.is_close && !do_pop;

  assign ctl.push = do_push;
  assign ctl.pop  = do_pop;

  genvar i;
  generate
    for (i = 0; i < STACK_DEPTH; i++) begin : g_slot
      kind_t above, below;
      if (i == 0) begin : g_top
        assign above = cls.kind;
      end else begin : g_mid
        assign above = slot_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
        assign below = KIND_PAREN;
      end else begin : g_up
        assign below = slot_q[i+1];
      end
      bmc_stack_cell u_slot (
        .clk        (clk),
        .ctl        (ctl),
        .from_above (above),
        .from_below (below),
        .kind_q     (slot_q[i])
      );
    end
  endgenerate

  always_comb begin
    level_nxt   = level_r;
    count_nxt   = count_r;
    stopped_nxt = stopped_r;
    mis_nxt     = mis_r;
    ovf_nxt     = ovf_r;
    if (do_push) begin
      level_nxt = level_r + 1'b1;
    end
    if (do_pop) begin
      level_nxt = level_r - 1'b1;
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + 16'd1;
      end
    end
    if (push_full) begin
      ovf_nxt     = 1'b1;
      stopped_nxt = 1'b1;
    end
    if (bad_close) begin
      mis_nxt     = 1'b1;
      stopped_nxt = 1'b1;
    end
    res.matched_pairs = count_nxt;
    res.left_open     = (level_nxt != '0);
    res.mismatch_seen = mis_nxt;
    res.overflow_seen = ovf_nxt;
    // end of string: report, then start the next string from scratch
    if (accept && in_ch.last_char) begin
      level_nxt   = '0;
      count_nxt   = '0;
      stopped_nxt = 1'b0;
      mis_nxt     = 1'b0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= '0;
      count_r   <= '0;
      stopped_r <= 1'b0;
      mis_r     <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      level_r   <= level_nxt;
      count_r   <= count_nxt;
      stopped_r <= stopped_nxt;
      mis_r     <= mis_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  bmc_out_buf u_out_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (accept && in_ch.last_char),
    .data   (res),
    .room   (room),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_FULL)
    else $error("stack level beyond depth");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last_char) |=> (level_r == '0 && count_r == '0 && !stopped_r))
    else $error("state not cleared after end of string");

  a_flag_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (mis_r || ovf_r) |-> stopped_r)
    else $error("error flag set without stopped scan");

  a_one_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !(mis_r && ovf_r))
    else $error("mismatch and overflow both set");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (stopped_r && !(accept && in_ch.last_char)) |=> $stable(level_r) && $stable(count_r))
    else $error("stack moved after scan stopped");
`endif

endmodule
